@@ rtl/core/assert_macros.svh @@
// assertion helpers, empty in synthesis
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// property must hold at every clock edge outside reset
`define PRU_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("%m: assertion failed");

// condition must never be seen outside reset
`define PRU_ASSERT_NEVER(lbl, clk, rst_n, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("%m: forbidden condition seen");

`else

`define PRU_ASSERT(lbl, clk, rst_n, prop)
`define PRU_ASSERT_NEVER(lbl, clk, rst_n, cond)

`endif

`endif

@@ rtl/core/pru_pkg.sv @@
package pru_pkg;

    // filter type codes
    localparam logic [2:0] FILT_NONE  = 3'd0;
    localparam logic [2:0] FILT_SUB   = 3'd1;
    localparam logic [2:0] FILT_UP    = 3'd2;
    localparam logic [2:0] FILT_AVG   = 3'd3;
    localparam logic [2:0] FILT_PAETH = 3'd4;

    localparam logic [7:0] FILT_TYPE_MAX = 8'd4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_ROW_BYTES   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PIXEL_BYTES = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_ROWS  = 2'd2;

    localparam int ROW_BYTES_W   = 14;
    localparam int PIXEL_BYTES_W = 4;
    localparam int IMAGE_ROWS_W  = 16;

    // width for count compares, holds a row count plus one
    localparam int CMP_W = 17;

    // paeth predictor, ties prefer a, then b, then c
    function automatic logic [7:0] paeth(input logic [7:0] a, input logic [7:0] b,
                                         input logic [7:0] c);
        logic signed [9:0] s_bc;
        logic signed [9:0] s_ac;
        logic signed [9:0] s_sum;
        logic [9:0]        da;
        logic [9:0]        db;
        logic [9:0]        dc;
        s_bc  = $signed({2'b00, b}) - $signed({2'b00, c});
        s_ac  = $signed({2'b00, a}) - $signed({2'b00, c});
        s_sum = s_bc + s_ac;
        da    = (s_bc < 0) ? 10'(-s_bc) : 10'(s_bc);
        db    = (s_ac < 0) ? 10'(-s_ac) : 10'(s_ac);
        dc    = (s_sum < 0) ? 10'(-s_sum) : 10'(s_sum);
        if (da <= db && da <= dc) begin
            return a;
        end else if (db <= dc) begin
            return b;
        end else begin
            return c;
        end
    endfunction

endpackage

@@ rtl/core/pru_in_if.sv @@
interface pru_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;

    modport source (output valid, output data_byte, input ready);
    modport sink (input valid, input data_byte, output ready);
endinterface

@@ rtl/core/pru_out_if.sv @@
interface pru_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] pixel_byte;
    logic       row_end;
    logic       image_end;
    logic       bad_filter;

    modport source (output valid, output pixel_byte, output row_end, output image_end,
                    output bad_filter, input ready);
    modport sink (input valid, input pixel_byte, input row_end, input image_end,
                  input bad_filter, output ready);
endinterface

@@ rtl/core/pru_line_buf.sv @@
module pru_line_buf #(
    parameter int DEPTH  = 8192,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              i_clk,
    input  logic              i_rd_en,
    input  logic [ADDR_W-1:0] i_rd_addr,
    output logic [7:0]        o_rd_data,
    input  logic              i_wr_en,
    input  logic [ADDR_W-1:0] i_wr_addr,
    input  logic [7:0]        i_wr_data
);

    logic [7:0] r_mem [DEPTH];
    logic [7:0] r_rd_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    // read data holds until the next read
    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

@@ rtl/core/png_row_unfilter.sv @@
// PNG row filter reconstruction, one stream byte per item.
// i_pix_in carries the decompressed stream: each row is a filter type byte
// (none, sub, up, average, paeth) followed by row_bytes filtered bytes.
// o_pix_out gives one item per data byte, flagged at row end and image end.
// A filter type above four gives one item with bad_filter set and a zero
// byte; the rest of that image is consumed with no output.
// Configuration: write i_cfg_data to register i_cfg_idx (0 row_bytes,
// 1 pixel_bytes, 2 image_rows) while the block is idle.
// Flow: an accepted item is held in the input register, processed out of it
// once the output register is free or being drained, and its result is
// loaded into the output register, which offers it from then on.
// Throughput: one item per cycle while the output is not held off. The
// previous row's byte is read from the line buffer, which has separate
// read and write ports, when an item is accepted, so the filter add and
// the paeth compare run when the item is processed with no extra wait.
// Reset: configuration registers go to 1, the next byte is taken as a filter
// type of the first row. The line buffer is not cleared; the first row masks it.
// Stall: once the output register is full and held off, one more item waits
// in the input register and i_pix_in.ready drops until the output drains.
`include "assert_macros.svh"

module png_row_unfilter #(
    parameter int ROW_MAX   = 8192,
    parameter int PIXEL_MAX = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_we,
    input  logic [pru_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [pru_pkg::CFG_DATA_W-1:0] i_cfg_data,
    pru_in_if.sink                         i_pix_in,
    pru_out_if.source                      o_pix_out
);

    localparam int COL_W  = $clog2(ROW_MAX);
    localparam int SLOT_W = (PIXEL_MAX > 1) ? $clog2(PIXEL_MAX) : 1;
    localparam int CMP_W  = pru_pkg::CMP_W;

    // configuration
    logic [pru_pkg::ROW_BYTES_W-1:0]   r_row_bytes;
    logic [pru_pkg::PIXEL_BYTES_W-1:0] r_pixel_bytes;
    logic [pru_pkg::IMAGE_ROWS_W-1:0]  r_image_rows;

    // stream state
    logic [COL_W-1:0]  r_col,    n_col;
    logic [15:0]       r_row,    n_row;
    logic              r_expect, n_expect;
    logic [2:0]        r_filter, n_filter;
    logic              r_skip,   n_skip;
    logic [SLOT_W-1:0] r_slot [PIXEL_MAX];
    logic [SLOT_W-1:0] n_slot [PIXEL_MAX];
    logic [7:0]        r_left [PIXEL_MAX];
    logic [7:0]        n_left [PIXEL_MAX];
    logic [7:0]        r_ul   [PIXEL_MAX];
    logic [7:0]        n_ul   [PIXEL_MAX];

    // input and output registers
    logic       r_in_valid;
    logic [7:0] r_in_byte;
    logic       r_out_valid;
    logic [7:0] r_out_pix;
    logic       r_out_row_end;
    logic       r_out_img_end;
    logic       r_out_bad;

    logic proc;
    logic in_fire;
    logic has_res;

    logic [CMP_W-1:0]                  rb_raw;
    logic [CMP_W-1:0]                  rb;
    logic [pru_pkg::PIXEL_BYTES_W-1:0] pb;
    logic [pru_pkg::PIXEL_BYTES_W-1:0] pb_m1;
    logic [15:0]                       nr;

    logic [SLOT_W-1:0] slot;
    logic              has_left;
    logic              last_col;
    logic              last_row;
    logic [7:0]        up_q;
    logic [7:0]        a_val;
    logic [7:0]        b_val;
    logic [7:0]        c_val;
    logic [7:0]        pred;
    logic [7:0]        v_val;
    logic              bad_type;

    logic             wr_en;
    logic [COL_W-1:0] rd_addr;

    // register clamping, zero acts as one
    assign rb_raw = CMP_W'(r_row_bytes);
    assign rb     = (rb_raw == '0) ? CMP_W'(1) :
                    (rb_raw > CMP_W'(ROW_MAX)) ? CMP_W'(ROW_MAX) : rb_raw;
    assign pb     = (r_pixel_bytes == '0) ? pru_pkg::PIXEL_BYTES_W'(1) :
                    (r_pixel_bytes > pru_pkg::PIXEL_BYTES_W'(PIXEL_MAX)) ?
                    pru_pkg::PIXEL_BYTES_W'(PIXEL_MAX) : r_pixel_bytes;
    assign pb_m1  = pb - pru_pkg::PIXEL_BYTES_W'(1);
    assign nr     = (r_image_rows == '0) ? 16'd1 : r_image_rows;

    // handshake
    assign proc           = r_in_valid && (!r_out_valid || o_pix_out.ready);
    assign i_pix_in.ready = !r_in_valid || proc;
    assign in_fire        = i_pix_in.valid && i_pix_in.ready;

    // col mod pb comes from a running counter per modulus
    assign slot     = r_slot[pb_m1[SLOT_W-1:0]];
    assign has_left = CMP_W'(r_col) >= CMP_W'(pb);
    assign last_col = (CMP_W'(r_col) + CMP_W'(1)) >= rb;
    assign last_row = (CMP_W'(r_row) + CMP_W'(1)) >= CMP_W'(nr);

    assign a_val = has_left ? r_left[slot] : 8'd0;
    assign b_val = (r_row != 16'd0) ? up_q : 8'd0;
    assign c_val = (has_left && r_row != 16'd0) ? r_ul[slot] : 8'd0;

    always_comb begin
        unique case (r_filter)
            pru_pkg::FILT_SUB:   pred = a_val;
            pru_pkg::FILT_UP:    pred = b_val;
            pru_pkg::FILT_AVG:   pred = 8'((9'(a_val) + 9'(b_val)) >> 1);
            pru_pkg::FILT_PAETH: pred = pru_pkg::paeth(a_val, b_val, c_val);
            default:             pred = 8'd0;
        endcase
    end

    assign v_val    = r_in_byte + pred;
    assign bad_type = r_in_byte > pru_pkg::FILT_TYPE_MAX;
    assign has_res  = proc && !r_skip && (!r_expect || bad_type);

    always_comb begin
        n_col    = r_col;
        n_row    = r_row;
        n_expect = r_expect;
        n_filter = r_filter;
        n_skip   = r_skip;
        n_slot   = r_slot;
        n_left   = r_left;
        n_ul     = r_ul;
        wr_en    = 1'b0;
        if (proc) begin
            if (r_expect) begin
                n_expect = 1'b0;
                if (!r_skip) begin
                    if (bad_type) begin
                        n_skip = 1'b1;
                    end else begin
                        n_filter = r_in_byte[2:0];
                    end
                end
            end else begin
                if (!r_skip) begin
                    n_ul[slot]   = b_val;
                    n_left[slot] = v_val;
                    wr_en        = 1'b1;
                end
                if (last_col) begin
                    n_col    = '0;
                    n_expect = 1'b1;
                    for (int p = 0; p < PIXEL_MAX; p++) begin
                        n_slot[p] = '0;
                    end
                    if (last_row) begin
                        n_row  = 16'd0;
                        n_skip = 1'b0;
                    end else begin
                        n_row = r_row + 16'd1;
                    end
                end else begin
                    n_col = r_col + COL_W'(1);
                    for (int p = 0; p < PIXEL_MAX; p++) begin
                        n_slot[p] = (r_slot[p] == SLOT_W'(p)) ? '0 :
                                    r_slot[p] + SLOT_W'(1);
                    end
                end
            end
        end
    end

    // read ahead at the column the accepted item will use
    assign rd_addr = proc ? n_col : r_col;

    pru_line_buf #(
        .DEPTH  (ROW_MAX),
        .ADDR_W (COL_W)
    ) u_line_buf (
        .i_clk     (i_clk),
        .i_rd_en   (in_fire),
        .i_rd_addr (rd_addr),
        .o_rd_data (up_q),
        .i_wr_en   (wr_en),
        .i_wr_addr (r_col),
        .i_wr_data (v_val)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_bytes   <= pru_pkg::ROW_BYTES_W'(1);
            r_pixel_bytes <= pru_pkg::PIXEL_BYTES_W'(1);
            r_image_rows  <= pru_pkg::IMAGE_ROWS_W'(1);
            r_col         <= '0;
            r_row         <= 16'd0;
            r_expect      <= 1'b1;
            r_filter      <= pru_pkg::FILT_NONE;
            r_skip        <= 1'b0;
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            for (int p = 0; p < PIXEL_MAX; p++) begin
                r_slot[p] <= '0;
                r_left[p] <= 8'd0;
                r_ul[p]   <= 8'd0;
            end
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    pru_pkg::CFG_ROW_BYTES:
                        r_row_bytes <= i_cfg_data[pru_pkg::ROW_BYTES_W-1:0];
                    pru_pkg::CFG_PIXEL_BYTES:
                        r_pixel_bytes <= i_cfg_data[pru_pkg::PIXEL_BYTES_W-1:0];
                    pru_pkg::CFG_IMAGE_ROWS:
                        r_image_rows <= i_cfg_data[pru_pkg::IMAGE_ROWS_W-1:0];
                    default: ;
                endcase
            end
            r_col    <= n_col;
            r_row    <= n_row;
            r_expect <= n_expect;
            r_filter <= n_filter;
            r_skip   <= n_skip;
            r_slot   <= n_slot;
            r_left   <= n_left;
            r_ul     <= n_ul;
            if (in_fire) begin
                r_in_valid <= 1'b1;
            end else if (proc) begin
                r_in_valid <= 1'b0;
            end
            if (has_res) begin
                r_out_valid <= 1'b1;
            end else if (o_pix_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_in_byte <= i_pix_in.data_byte;
        end
        if (has_res) begin
            r_out_pix     <= r_expect ? 8'd0 : v_val;
            r_out_row_end <= !r_expect && last_col;
            r_out_img_end <= !r_expect && last_col && last_row;
            r_out_bad     <= r_expect;
        end
    end

    assign o_pix_out.valid      = r_out_valid;
    assign o_pix_out.pixel_byte = r_out_pix;
    assign o_pix_out.row_end    = r_out_row_end;
    assign o_pix_out.image_end  = r_out_img_end;
    assign o_pix_out.bad_filter = r_out_bad;

    `PRU_ASSERT(a_bad_item_empty, i_clk, i_rst_n, r_out_valid && r_out_bad |-> r_out_pix == 8'd0 && !r_out_row_end && !r_out_img_end)
    `PRU_ASSERT_NEVER(a_img_end_row_end, i_clk, i_rst_n, r_out_valid && r_out_img_end && !r_out_row_end)
    `PRU_ASSERT(a_type_at_col0, i_clk, i_rst_n, r_expect |-> r_col == '0)
    `PRU_ASSERT(a_in_held, i_clk, i_rst_n, r_in_valid && !proc |=> r_in_valid && $stable(r_in_byte))

endmodule
